// ===== sv/bba_pkg.sv =====
// Shared constants, types and codes for the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int NUM_BLOCKS    = 1024;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
    localparam int WORD_W        = $clog2(MAP_WORDS);
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int BLK_W         = 10;
    localparam int CFG_W         = 11;
    localparam int NUM_LIMIT     = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;

    localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(1024);

    typedef logic [MAP_WORD_BITS-1:0] t_word;
    typedef logic [WORD_W-1:0]        t_word_addr;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_FULL        = 2'd1;
    localparam t_status ST_DOUBLE_FREE = 2'd2;
    localparam t_status ST_RANGE       = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic       rd_en;
        t_word_addr rd_addr;
        logic       wr_en;
        t_word_addr wr_addr;
        t_word      wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== sv/bitmap_block_allocator_core.sv =====
// Top level of the bitmap first-fit block allocator.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low. Each transaction yields one result on o_block_number_res and o_status,
// shown for exactly one cycle while o_res_valid is high; the receiver cannot
// stall it. The total_blocks register is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must do so only while the block is idle, as the
// block itself does not enforce it. An allocation reads one bitmap word per
// cycle from word zero upward, at most 32 words for 1024 blocks, until it
// finds a free bit or has read the last word in range. A free takes one
// read-modify-write. A free out of range, or an allocation with a zero total,
// answers in the cycle after acceptance. The next transaction can be accepted
// in the cycle its predecessor's result is shown. The bitmap memory's single
// read port sets the scan rate. Reset marks every block free through per-word
// valid bits at once, with no clearing pass, and sets total_blocks to 1024.
`default_nettype none

module bitmap_block_allocator_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_req_type,
    input  wire [bba_pkg::BLK_W-1:0]         i_block_number,
    input  wire                              i_cfg_wr_en,
    input  wire [bba_pkg::CFG_W-1:0]         i_cfg_wr_data,
    output logic                             o_res_valid,
    output logic [bba_pkg::BLK_W-1:0]        o_block_number_res,
    output logic [1:0]                       o_status
);

    logic [bba_pkg::CFG_W-1:0] r_total_blocks;
    logic [bba_pkg::CFG_W-1:0] limit;
    bba_pkg::t_mem_req         mem_req;
    bba_pkg::t_word            mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= bba_pkg::TOTAL_RESET;
        end else if (i_cfg_wr_en) begin
            r_total_blocks <= i_cfg_wr_data;
        end
    end

    assign limit = (r_total_blocks > bba_pkg::CFG_W'(bba_pkg::NUM_LIMIT))
                 ? bba_pkg::CFG_W'(bba_pkg::NUM_LIMIT) : r_total_blocks;

    bba_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_req_type         (i_req_type),
        .i_block_number     (i_block_number),
        .i_limit            (limit),
        .i_rdata            (mem_rdata),
        .o_busy             (busy),
        .o_mem              (mem_req),
        .o_res_valid        (o_res_valid),
        .o_block_number_res (o_block_number_res),
        .o_status           (o_status)
    );

    bba_map_mem u_map_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (mem_req),
        .o_rdata (mem_rdata)
    );

`ifndef ASSERT_OFF
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == bba_pkg::ST_FULL)) |-> (o_block_number_res == '0))
        else $error("out-of-blocks result carries a nonzero block number");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == bba_pkg::ST_OK)) |-> ({1'b0, o_block_number_res} < limit))
        else $error("successful result names a block at or above the limit");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_res_valid)
        else $error("busy dropped without a result strobe");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(busy) || $past(start)))
        else $error("result strobe without a transaction in flight");
`endif

endmodule

`default_nettype wire

// ===== sv/bba_map_mem.sv =====
// Bitmap word memory with registered read and per-word valid bits.
`default_nettype none

module bba_map_mem (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire bba_pkg::t_mem_req i_mem,
    output bba_pkg::t_word      o_rdata
);

    bba_pkg::t_word                   mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0]    r_valid;
    bba_pkg::t_word                   r_rdata;
    logic                             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        if (i_mem.rd_en) begin
            r_rdata <= mem[i_mem.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_mem.wr_en) begin
                r_valid[i_mem.wr_addr] <= 1'b1;
            end
            if (i_mem.rd_en) begin
                r_rd_valid <= r_valid[i_mem.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

`default_nettype wire

// ===== sv/bba_ctrl.sv =====
// Request sequencer: word scan for allocation, read-modify-write for free.
`default_nettype none

module bba_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              i_req_type,
    input  wire [bba_pkg::BLK_W-1:0]         i_block_number,
    input  wire [bba_pkg::CFG_W-1:0]         i_limit,
    input  wire bba_pkg::t_word              i_rdata,
    output logic                             o_busy,
    output bba_pkg::t_mem_req                o_mem,
    output logic                             o_res_valid,
    output logic [bba_pkg::BLK_W-1:0]        o_block_number_res,
    output bba_pkg::t_status                 o_status
);

    bba_pkg::t_state                 r_state;
    bba_pkg::t_state                 n_state;
    logic [bba_pkg::BLK_W-1:0]       r_req_blk;
    logic [bba_pkg::BLK_W-1:0]       n_req_blk;
    bba_pkg::t_word_addr             r_word;
    bba_pkg::t_word_addr             n_word;
    logic                            r_res_valid;
    logic                            n_res_valid;
    logic [bba_pkg::BLK_W-1:0]       r_res_blk;
    logic [bba_pkg::BLK_W-1:0]       n_res_blk;
    bba_pkg::t_status                r_status;
    bba_pkg::t_status                n_status;

    logic [bba_pkg::CFG_W-1:0]       limit_m1;
    bba_pkg::t_word_addr             last_word;
    logic [bba_pkg::CFG_W-1:0]       rem_full;
    logic [bba_pkg::BIT_W:0]         rem;
    bba_pkg::t_word                  valid_mask;
    bba_pkg::t_word                  free_bits;
    logic                            free_any;
    logic [bba_pkg::BIT_W-1:0]       free_idx;
    bba_pkg::t_word                  free_onehot;
    bba_pkg::t_word                  req_onehot;
    logic                            req_bit_set;
    logic                            blk_out_of_range;

    assign limit_m1  = i_limit - bba_pkg::CFG_W'(1);
    assign last_word = limit_m1[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign rem_full  = i_limit - {1'b0, last_word, bba_pkg::BIT_W'(0)};
    assign rem       = rem_full[bba_pkg::BIT_W:0];

    always_comb begin
        for (int i = 0; i < bba_pkg::MAP_WORD_BITS; i++) begin
            valid_mask[i] = (r_word != last_word) || ((bba_pkg::BIT_W + 1)'(i) < rem);
        end
    end

    assign free_bits = ~i_rdata & valid_mask;
    assign free_any  = |free_bits;

    always_comb begin
        free_idx = '0;
        for (int i = bba_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = bba_pkg::BIT_W'(i);
            end
        end
    end

    assign free_onehot = bba_pkg::t_word'(1) << free_idx;
    assign req_onehot  = bba_pkg::t_word'(1) << r_req_blk[bba_pkg::BIT_W-1:0];
    assign req_bit_set = i_rdata[r_req_blk[bba_pkg::BIT_W-1:0]];
    assign blk_out_of_range = {1'b0, i_block_number} >= i_limit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == bba_pkg::REQ_ALLOC) begin
                        if (i_limit != '0) begin
                            n_state = bba_pkg::S_SCAN;
                        end
                    end else if (!blk_out_of_range) begin
                        n_state = bba_pkg::S_FREE;
                    end
                end
            end
            bba_pkg::S_SCAN: begin
                if (free_any || (r_word == last_word)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_FREE: begin
                n_state = bba_pkg::S_IDLE;
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_mem       = '0;
        n_req_blk   = r_req_blk;
        n_word      = r_word;
        n_res_valid = 1'b0;
        n_res_blk   = r_res_blk;
        n_status    = r_status;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req_blk     = i_block_number;
                    n_word        = '0;
                    o_mem.rd_en   = 1'b1;
                    if (i_req_type == bba_pkg::REQ_ALLOC) begin
                        o_mem.rd_addr = '0;
                        if (i_limit == '0) begin
                            n_res_valid = 1'b1;
                            n_res_blk   = '0;
                            n_status    = bba_pkg::ST_FULL;
                        end
                    end else begin
                        o_mem.rd_addr = i_block_number[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
                        if (blk_out_of_range) begin
                            n_res_valid = 1'b1;
                            n_res_blk   = i_block_number;
                            n_status    = bba_pkg::ST_RANGE;
                        end
                    end
                end
            end
            bba_pkg::S_SCAN: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_word + bba_pkg::WORD_W'(1);
                n_word        = r_word + bba_pkg::WORD_W'(1);
                if (free_any) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_word;
                    o_mem.wr_data = i_rdata | free_onehot;
                    n_res_valid   = 1'b1;
                    n_res_blk     = {r_word, free_idx};
                    n_status      = bba_pkg::ST_OK;
                end else if (r_word == last_word) begin
                    n_res_valid = 1'b1;
                    n_res_blk   = '0;
                    n_status    = bba_pkg::ST_FULL;
                end
            end
            bba_pkg::S_FREE: begin
                n_res_valid = 1'b1;
                n_res_blk   = r_req_blk;
                if (req_bit_set) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_req_blk[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
                    o_mem.wr_data = i_rdata & ~req_onehot;
                    n_status      = bba_pkg::ST_OK;
                end else begin
                    n_status = bba_pkg::ST_DOUBLE_FREE;
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_blk <= n_req_blk;
        r_word    <= n_word;
        r_res_blk <= n_res_blk;
        r_status  <= n_status;
    end

    assign o_busy             = (r_state != bba_pkg::S_IDLE);
    assign o_res_valid        = r_res_valid;
    assign o_block_number_res = r_res_blk;
    assign o_status           = r_status;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the bitmap first-fit block allocator core.
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int FILL_TOTAL   = 80;
    localparam int MIX_ITEMS    = 36;

    typedef struct packed {
        logic [bba_pkg::BLK_W-1:0] blk;
        bba_pkg::t_status          status;
    } t_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      i_req_type = bba_pkg::REQ_ALLOC;
    logic [bba_pkg::BLK_W-1:0] i_block_number = '0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [bba_pkg::CFG_W-1:0] i_cfg_wr_data = '0;
    wire                       busy;
    wire                       o_res_valid;
    wire [bba_pkg::BLK_W-1:0]  o_block_number_res;
    wire [1:0]                 o_status;

    bitmap_block_allocator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_block_number     (i_block_number),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_res_valid        (o_res_valid),
        .o_block_number_res (o_block_number_res),
        .o_status           (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit                        used_blocks [bba_pkg::NUM_BLOCKS];
    logic [bba_pkg::CFG_W-1:0] total_cfg = bba_pkg::TOTAL_RESET;
    t_reply                    replies_due [$];
    int                        fails = 0;
    int                        cycle_count = 0;
    int                        burst_left = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("bitmap_block_allocator_core test failed");
            $finish;
        end
    end

    function automatic int active_limit();
        int lim;
        lim = int'(total_cfg);
        if (lim > bba_pkg::NUM_BLOCKS) lim = bba_pkg::NUM_BLOCKS;
        if (lim > 1024) lim = 1024;
        return lim;
    endfunction

    function automatic t_reply apply_request(logic req, logic [bba_pkg::BLK_W-1:0] blk);
        t_reply r;
        int lim;
        lim = active_limit();
        r.blk = '0;
        r.status = bba_pkg::ST_FULL;
        if (req == bba_pkg::REQ_ALLOC) begin
            for (int b = 0; b < lim; b++) begin
                if (!used_blocks[b]) begin
                    used_blocks[b] = 1'b1;
                    r.blk = bba_pkg::BLK_W'(b);
                    r.status = bba_pkg::ST_OK;
                    break;
                end
            end
        end else begin
            r.blk = blk;
            if (int'(blk) >= lim) begin
                r.status = bba_pkg::ST_RANGE;
            end else if (!used_blocks[blk]) begin
                r.status = bba_pkg::ST_DOUBLE_FREE;
            end else begin
                used_blocks[blk] = 1'b0;
                r.status = bba_pkg::ST_OK;
            end
        end
        return r;
    endfunction

    function automatic int find_used(int lim);
        int first;
        int b;
        if (lim <= 0) return -1;
        first = $urandom_range(0, lim - 1);
        for (int i = 0; i < lim; i++) begin
            b = (first + i) % lim;
            if (used_blocks[b]) return b;
        end
        return -1;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_res_valid) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result: block_number_res %0d status %0d",
                       o_block_number_res, o_status);
                fails++;
            end else begin
                want = replies_due.pop_front();
                if (o_block_number_res !== want.blk) begin
                    $error("block_number_res expected %0d actual %0d",
                           want.blk, o_block_number_res);
                    fails++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    fails++;
                end
            end
        end
    end

    task automatic send_request(input logic req, input int blk);
        @(negedge i_clk);
        start <= 1'b1;
        i_req_type <= req;
        i_block_number <= bba_pkg::BLK_W'(blk);
        do @(posedge i_clk); while (busy);
        replies_due.push_back(apply_request(req, bba_pkg::BLK_W'(blk)));
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_total(input int value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= bba_pkg::CFG_W'(value);
        total_cfg = bba_pkg::CFG_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_alloc_free_basic();
        send_request(bba_pkg::REQ_ALLOC, 1023);
        send_request(bba_pkg::REQ_ALLOC, 0);
        send_request(bba_pkg::REQ_FREE, 0);
        send_request(bba_pkg::REQ_FREE, 0);
        send_request(bba_pkg::REQ_FREE, 1023);
        send_request(bba_pkg::REQ_ALLOC, 0);
    endtask

    task automatic test_total_extremes();
        write_total(0);
        send_request(bba_pkg::REQ_ALLOC, 0);
        send_request(bba_pkg::REQ_FREE, 0);
        send_request(bba_pkg::REQ_FREE, 1023);
        write_total(1);
        send_request(bba_pkg::REQ_ALLOC, 0);
        send_request(bba_pkg::REQ_FREE, 1);
        send_request(bba_pkg::REQ_FREE, 0);
        send_request(bba_pkg::REQ_ALLOC, 0);
        write_total(2047);
        send_request(bba_pkg::REQ_FREE, 1);
        send_request(bba_pkg::REQ_FREE, 1023);
        send_request(bba_pkg::REQ_ALLOC, 0);
    endtask

    task automatic test_fill_all();
        int order [FILL_TOTAL];
        int j;
        int tmp;
        write_total(FILL_TOTAL);
        for (int i = 0; i < FILL_TOTAL + 2; i++) begin
            send_request(bba_pkg::REQ_ALLOC, $urandom_range(0, 1023));
            pace();
        end
        for (int i = 0; i < FILL_TOTAL; i++) order[i] = i;
        for (int i = FILL_TOTAL - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < FILL_TOTAL; i++) begin
            send_request(bba_pkg::REQ_FREE, order[i]);
            pace();
        end
    endtask

    task automatic test_random_mix();
        int value;
        int lim;
        int r;
        int b;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: value = 1;
                1: value = 2047;
                2: value = 0;
                3: value = 32;
                4: value = 33;
                5: value = $urandom_range(1, 1024);
                6: value = 1024;
                7: value = $urandom_range(2, 64);
                default: value = $urandom_range(1, 2047);
            endcase
            write_total(value);
            for (int i = 0; i < MIX_ITEMS; i++) begin
                if (p == 4 && i == 25) wait_drained();
                lim = active_limit();
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    send_request(bba_pkg::REQ_ALLOC, $urandom_range(0, 1023));
                end else if (r < 80) begin
                    b = find_used(lim);
                    if (b < 0) send_request(bba_pkg::REQ_ALLOC, $urandom_range(0, 1023));
                    else send_request(bba_pkg::REQ_FREE, b);
                end else if (r < 90) begin
                    send_request(bba_pkg::REQ_FREE, $urandom_range(0, 1023));
                end else begin
                    b = lim - 1 + int'($urandom_range(0, 2));
                    if (b < 0) b = 0;
                    if (b > 1023) b = 1023;
                    send_request(bba_pkg::REQ_FREE, b);
                end
                pace();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < bba_pkg::NUM_BLOCKS; i++) used_blocks[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_alloc_free_basic();
        test_total_extremes();
        test_fill_all();
        test_random_mix();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d results never arrived", replies_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("bitmap_block_allocator_core test passed");
        end else begin
            $display("bitmap_block_allocator_core test failed");
        end
        $finish;
    end

endmodule
